// ----- hw/rtl/voxel_line_max_rasterizer_assert.svh -----
// Assertion macros used by the voxel line max-rasteriser walker.
`ifndef VOXEL_LINE_MAX_RASTERIZER_ASSERT_SVH
`define VOXEL_LINE_MAX_RASTERIZER_ASSERT_SVH

// Same-cycle implication on clk, held off while arst_n is low.
`define VLMR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, held off while arst_n is low.
`define VLMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/vlmr_pkg.sv -----
// Package: sizes, types and address helpers of the voxel line max-rasteriser.
package vlmr_pkg;

	localparam int VOL_DIM     = 32;
	localparam int VALUE_WIDTH = 16;
	localparam int COORD_W     = 11;
	localparam int VAL_IN_W    = 16;
	localparam int OUT_W       = 16;
	localparam int VOXELS      = VOL_DIM * VOL_DIM * VOL_DIM;
	localparam int ADDR_W      = $clog2(VOXELS);
	localparam int DIST_W      = COORD_W + 1;
	localparam int ERR_W       = COORD_W + 4;
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [DIST_W-1:0]          dist_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic [VALUE_WIDTH-1:0]     val_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic {
		KIND_DRAW,
		KIND_READ
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_RD,
		ST_RDW
	} back_state_t;

	typedef struct packed {
		kind_t            kind;
		coord_t [2:0]     p;
		coord_t           to_dom;
		dist_t  [2:0]     a;
		logic   [2:0]     neg;
		logic   [2:0]     nz;
		axis_t            dom;
		err_t   [2:0]     err;
		val_t             val;
	} item_t;

	function automatic logic in_vol(input coord_t [2:0] p);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (p[i] < 0 || p[i] >= VOL_DIM)
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic addr_t voxel_addr(input coord_t [2:0] p);
		addr_t r;
		r = (addr_t'($unsigned(p[2])) * addr_t'(VOL_DIM) + addr_t'($unsigned(p[1])))
			* addr_t'(VOL_DIM) + addr_t'($unsigned(p[0]));
		return r;
	endfunction

endpackage

// ----- hw/rtl/voxel_line_max_rasterizer.sv -----
// Top level: voxel line max-rasteriser with a 3D Bresenham walker over a voxel RAM.
// After reset the block sweeps the voxel RAM to zero, one voxel a cycle, and holds
// busy high until the sweep is done. An item is transferred when start is high and
// busy is low; a two-entry queue takes items while the walker works and, after the
// sweep, busy only rises when it is full. Each item gives one result, shown on
// read_value and in_range for exactly one cycle while done is high; the receiver
// cannot stall it. A read passes states ST_RD and ST_RDW; a draw walks the line's
// N = max(|dx|,|dy|,|dz|) + 1 voxels, one read-modify-write per voxel on the RAM's
// single write and single read port, then passes ST_DRAIN. Draw results carry zeros.
module voxel_line_max_rasterizer import vlmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 kind,
	input  logic [COORD_W-1:0]   x_start,
	input  logic [COORD_W-1:0]   y_start,
	input  logic [COORD_W-1:0]   z_start,
	input  logic [COORD_W-1:0]   x_end,
	input  logic [COORD_W-1:0]   y_end,
	input  logic [COORD_W-1:0]   z_end,
	input  logic [VAL_IN_W-1:0]  value,
	output logic                 done,
	output logic [OUT_W-1:0]     read_value,
	output logic                 in_range
);

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	logic   clearing;
	item_t  item;
	item_t  head;
	logic   ram_we;
	addr_t  ram_waddr;
	val_t   ram_wdata;
	addr_t  ram_raddr;
	val_t   ram_rdata;

	vlmr_front u_front (
		.start    (start),
		.kind     (kind),
		.x_start  (x_start),
		.y_start  (y_start),
		.z_start  (z_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.z_end    (z_end),
		.value    (value),
		.full     (full),
		.clearing (clearing),
		.busy     (busy),
		.push     (push),
		.item     (item)
	);

	vlmr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (item),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	vlmr_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.clearing   (clearing),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.done       (done),
		.read_value (read_value),
		.in_range   (in_range)
	);

	vlmr_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (VOXELS)
	) u_volume (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- hw/rtl/vlmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vlmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/vlmr_front.sv -----
// Front end: takes command transfers and sets up the line walk parameters.
module vlmr_front import vlmr_pkg::*; (
	input  logic                   start,
	input  logic                   kind,
	input  logic [COORD_W-1:0]     x_start,
	input  logic [COORD_W-1:0]     y_start,
	input  logic [COORD_W-1:0]     z_start,
	input  logic [COORD_W-1:0]     x_end,
	input  logic [COORD_W-1:0]     y_end,
	input  logic [COORD_W-1:0]     z_end,
	input  logic [VAL_IN_W-1:0]    value,
	input  logic                   full,
	input  logic                   clearing,
	output logic                   busy,
	output logic                   push,
	output item_t                  item
);

	coord_t [2:0]                 from_c;
	coord_t [2:0]                 to_c;
	logic signed [COORD_W:0]      d   [3];
	logic signed [COORD_W:0]      mag [3];
	dist_t  [2:0]                 a;
	axis_t                        dom;
	dist_t                        half;

	assign from_c[0] = coord_t'(x_start);
	assign from_c[1] = coord_t'(y_start);
	assign from_c[2] = coord_t'(z_start);
	assign to_c[0]   = coord_t'(x_end);
	assign to_c[1]   = coord_t'(y_end);
	assign to_c[2]   = coord_t'(z_end);

	assign busy = full | clearing;
	assign push = start & ~busy;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]   = {to_c[i][COORD_W-1], to_c[i]} - {from_c[i][COORD_W-1], from_c[i]};
			mag[i] = d[i][COORD_W] ? -d[i] : d[i];
			a[i]   = {mag[i][COORD_W-1:0], 1'b0};
		end
		if (a[0] >= a[1] && a[0] >= a[2])
			dom = AXIS_X;
		else if (a[1] >= a[2])
			dom = AXIS_Y;
		else
			dom = AXIS_Z;
		half = a[dom] >> 1;

		item.kind   = kind ? KIND_READ : KIND_DRAW;
		item.p      = from_c;
		item.to_dom = to_c[dom];
		item.a      = a;
		item.dom    = dom;
		item.val    = val_t'(value);
		for (int i = 0; i < 3; i++) begin
			item.neg[i] = d[i][COORD_W];
			item.nz[i]  = (d[i] != '0);
			item.err[i] = err_t'(a[i]) - err_t'(half);
		end
	end

endmodule

// ----- hw/rtl/vlmr_fifo.sv -----
// Short item queue between the front end and the walker.
module vlmr_fifo import vlmr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item_in,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= item_in;
	end

endmodule

// ----- hw/rtl/vlmr_walk.sv -----
// Back end: volume clear, line walk with max-write, voxel reads and results.
module vlmr_walk import vlmr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  logic               empty,
	output logic               pop,
	output logic               clearing,
	output logic               ram_we,
	output addr_t              ram_waddr,
	output val_t               ram_wdata,
	output addr_t              ram_raddr,
	input  val_t               ram_rdata,
	output logic               done,
	output logic [OUT_W-1:0]   read_value,
	output logic               in_range
);

	`include "voxel_line_max_rasterizer_assert.svh"

	back_state_t        state_q;
	back_state_t        state_d;
	item_t              cur_q;
	addr_t              clr_q;
	logic               wr_s1;
	logic               hit_s1;
	addr_t              addr_s1;
	logic               done_q;
	logic [OUT_W-1:0]   read_value_q;
	logic               in_range_q;

	logic               at_end;
	logic               hit;
	dist_t              a_dom;
	coord_t [2:0]       stp;
	coord_t [2:0]       p_n;
	err_t   [2:0]       err_n;

	assign hit       = in_vol(cur_q.p);
	assign at_end    = (cur_q.p[cur_q.dom] == cur_q.to_dom);
	assign a_dom     = cur_q.a[cur_q.dom];
	assign ram_raddr = voxel_addr(cur_q.p);
	assign clearing  = (state_q == ST_CLEAR);

	always_comb begin
		p_n   = cur_q.p;
		err_n = cur_q.err;
		for (int i = 0; i < 3; i++) begin
			stp[i] = !cur_q.nz[i] ? coord_t'(0) : (cur_q.neg[i] ? coord_t'(-1) : coord_t'(1));
			if (cur_q.dom == axis_t'(i)) begin
				p_n[i] = cur_q.p[i] + stp[i];
			end else if (!cur_q.err[i][ERR_W-1]) begin
				p_n[i]   = cur_q.p[i] + stp[i];
				err_n[i] = cur_q.err[i] - err_t'(a_dom) + err_t'(cur_q.a[i]);
			end else begin
				err_n[i] = cur_q.err[i] + err_t'(cur_q.a[i]);
			end
		end
	end

	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_s1 && (cur_q.val > ram_rdata);
			ram_waddr = addr_s1;
			ram_wdata = cur_q.val;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == addr_t'(VOXELS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = (head.kind == KIND_READ) ? ST_RD : ST_WALK;
				end
			end
			ST_WALK: begin
				if (at_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_IDLE;
			ST_RD:    state_d = ST_RDW;
			ST_RDW:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			wr_s1        <= 1'b0;
			hit_s1       <= 1'b0;
			done_q       <= 1'b0;
			in_range_q   <= 1'b0;
			read_value_q <= '0;
		end else begin
			if (clearing)
				clr_q <= clr_q + addr_t'(1);
			wr_s1  <= (state_q == ST_WALK) && hit;
			hit_s1 <= hit;
			done_q <= (state_q == ST_DRAIN) || (state_q == ST_RDW);
			if (state_q == ST_RDW) begin
				in_range_q   <= hit_s1;
				read_value_q <= hit_s1 ? OUT_W'(ram_rdata) : '0;
			end else begin
				in_range_q   <= 1'b0;
				read_value_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ram_raddr;
		if (pop) begin
			cur_q <= head;
		end else if (state_q == ST_WALK && !at_end) begin
			cur_q.p   <= p_n;
			cur_q.err <= err_n;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign in_range   = in_range_q;

	`VLMR_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held over two cycles")
	`VLMR_ASSERT_NOW(a_range_needs_done, in_range_q, done_q, "in_range set without a result")
	`VLMR_ASSERT_NOW(a_miss_reads_zero, done_q && !in_range_q, read_value_q == '0, "stray read value")
	`VLMR_ASSERT_NOW(a_write_after_issue, ram_we && !clearing, wr_s1, "write with no read issued")

endmodule
